### rtl/lsct_pkg.sv
// Package for the slot cache tracker: sizes of the slot table, keys, ticks
// and counters. No dependencies.
package lsct_pkg;

  // Slot table depth and the index and count widths that follow from it.
  localparam int MAX_SLOTS = 64;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = SLOT_W + 1;

  // Field widths of one beat on each channel.
  localparam int LAYER_W   = 7;
  localparam int EXPERT_W  = 9;
  localparam int KEY_W     = LAYER_W + EXPERT_W;
  localparam int CFG_W     = 7;
  localparam int IDX_OUT_W = 6;
  localparam int TICK_W    = 64;
  localparam int CTR_W     = 32;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [TICK_W-1:0] tick_t;
  typedef logic [CTR_W-1:0]  ctr_t;

  // Saturating counter increment.
  function automatic ctr_t sat_inc(input ctr_t v);
    sat_inc = (v == '1) ? v : v + ctr_t'(1);
  endfunction

endpackage

### rtl/lru_slot_cache_tracker.sv
// Top level of the slot cache tracker: an LRU-managed fully associative
// table of (layer, expert) keys with a sequential scan engine.
// Depends on lsct_pkg.

// Each request beat looks up one (layer, expert) key among the slots in use.
// The key and last-use tick tables live in memories with one write port and
// one registered read port, which one compare engine scans one slot per
// cycle. In bypass (slot_count of zero) the scan and the update step are
// skipped. The next request can be accepted in the same cycle as the result
// beat. The input is stalled while a request is being scanned, and while its
// result waits for the output register to free up. A finished result waits
// in the output register while the next request is taken. A hit stamps the
// slot with a new tick. A miss fills the lowest empty slot or evicts the
// least recently used one (lowest index on a tie). Writing cfg_slot_count
// empties all slots at once but keeps the use clock and the saturating hit,
// miss and eviction counters. Counts above the table depth use the whole
// table. Configure only while no request is open.
module lru_slot_cache_tracker (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration port
  input  logic                           cfg_we,
  input  logic [lsct_pkg::CFG_W-1:0]     cfg_slot_count,
  // Request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [lsct_pkg::LAYER_W-1:0]   in_layer_id,
  input  logic [lsct_pkg::EXPERT_W-1:0]  in_expert_id,
  // Result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_hit,
  output logic                           out_bypass,
  output logic [lsct_pkg::IDX_OUT_W-1:0] out_slot_index,
  output logic                           out_evicted,
  output logic [lsct_pkg::LAYER_W-1:0]   out_evicted_layer,
  output logic [lsct_pkg::EXPERT_W-1:0]  out_evicted_expert,
  output logic [lsct_pkg::CTR_W-1:0]     out_hit_total,
  output logic [lsct_pkg::CTR_W-1:0]     out_miss_total,
  output logic [lsct_pkg::CTR_W-1:0]     out_evict_total
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  localparam logic [lsct_pkg::CNT_W-1:0] MAX_CNT = lsct_pkg::CNT_W'(lsct_pkg::MAX_SLOTS);

  logic [1:0] state_r, state_nxt;

  // Configuration and persistent state.
  logic [lsct_pkg::CNT_W-1:0]     active_r;
  logic [lsct_pkg::MAX_SLOTS-1:0] valid_r;
  lsct_pkg::tick_t                use_clock_r;
  lsct_pkg::ctr_t                 hits_r, misses_r, evicts_r;

  // Slot memories.
  lsct_pkg::key_t  key_mem  [lsct_pkg::MAX_SLOTS];
  lsct_pkg::tick_t tick_mem [lsct_pkg::MAX_SLOTS];
  lsct_pkg::key_t  key_q_r;
  lsct_pkg::tick_t tick_q_r;

  // Scan engine.
  lsct_pkg::key_t              key_r;
  logic [lsct_pkg::CNT_W-1:0]  rd_idx_r;
  logic                        rd_en;
  logic                        cmp_vld_r;
  logic [lsct_pkg::SLOT_W-1:0] cmp_idx_r;
  logic                        cmp_valid;
  logic                        found_r, empty_r, least_vld_r;
  logic [lsct_pkg::SLOT_W-1:0] hit_idx_r, empty_idx_r, least_idx_r;
  lsct_pkg::tick_t             least_tick_r;
  lsct_pkg::key_t              least_key_r;
  logic                        scan_last;

  // Update step.
  logic                        mem_we;
  logic [lsct_pkg::SLOT_W-1:0] pick_idx;
  lsct_pkg::tick_t             tick_nxt;

  // Result held until the output register is free.
  logic                        res_hit_r, res_bypass_r, res_evicted_r;
  logic [lsct_pkg::SLOT_W-1:0] res_slot_r;
  lsct_pkg::key_t              res_key_r;

  // Output register.
  logic                           out_valid_r;
  logic                           out_hit_r, out_bypass_r, out_evicted_r;
  logic [lsct_pkg::IDX_OUT_W-1:0] out_slot_r;
  lsct_pkg::key_t                 out_key_r;
  lsct_pkg::ctr_t                 out_hits_r, out_misses_r, out_evicts_r;

  logic in_accept, out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign rd_en     = (state_r == ST_SCAN) && (rd_idx_r < active_r);
  assign cmp_valid = valid_r[cmp_idx_r];
  assign scan_last = cmp_vld_r && ({1'b0, cmp_idx_r} == active_r - 1'b1);
  assign mem_we    = (state_r == ST_UPDATE);
  assign pick_idx  = found_r ? hit_idx_r : (empty_r ? empty_idx_r : least_idx_r);
  assign tick_nxt  = use_clock_r + lsct_pkg::tick_t'(1);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = (active_r == '0) ? ST_RESULT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: state_nxt = ST_RESULT;
      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Slot count register; counts above the table depth use the whole table.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (cfg_we) begin
      active_r <= (cfg_slot_count > lsct_pkg::CFG_W'(MAX_CNT)) ? MAX_CNT
                                                               : cfg_slot_count;
    end
  end

  // Valid bits: cleared by reset and by a slot count write, set on fill.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      valid_r <= '0;
    end else if (mem_we) begin
      valid_r[pick_idx] <= 1'b1;
    end
  end

  // Key and tick memories: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[pick_idx]  <= key_r;
      tick_mem[pick_idx] <= tick_nxt;
    end
    if (rd_en) begin
      key_q_r  <= key_mem[rd_idx_r[lsct_pkg::SLOT_W-1:0]];
      tick_q_r <= tick_mem[rd_idx_r[lsct_pkg::SLOT_W-1:0]];
    end
  end

  // Read address counter and compare stage alignment.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r  <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= rd_en;
      if (in_accept) begin
        rd_idx_r <= '0;
      end else if (rd_en) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cmp_idx_r <= rd_idx_r[lsct_pkg::SLOT_W-1:0];
    end
    if (in_accept) begin
      key_r <= {in_layer_id, in_expert_id};
    end
  end

  // Compare stage: first hit, first empty slot, least tick among valid slots.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r     <= 1'b0;
      empty_r     <= 1'b0;
      least_vld_r <= 1'b0;
    end else if (in_accept) begin
      found_r     <= 1'b0;
      empty_r     <= 1'b0;
      least_vld_r <= 1'b0;
    end else if (cmp_vld_r) begin
      if (cmp_valid && (key_q_r == key_r) && !found_r) begin
        found_r <= 1'b1;
      end
      if (!cmp_valid && !empty_r) begin
        empty_r <= 1'b1;
      end
      if (cmp_valid && (!least_vld_r || (tick_q_r < least_tick_r))) begin
        least_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_vld_r) begin
      if (cmp_valid && (key_q_r == key_r) && !found_r) begin
        hit_idx_r <= cmp_idx_r;
      end
      if (!cmp_valid && !empty_r) begin
        empty_idx_r <= cmp_idx_r;
      end
      if (cmp_valid && (!least_vld_r || (tick_q_r < least_tick_r))) begin
        least_tick_r <= tick_q_r;
        least_idx_r  <= cmp_idx_r;
        least_key_r  <= key_q_r;
      end
    end
  end

  // Use clock and saturating counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_clock_r <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      evicts_r    <= '0;
    end else if (in_accept && (active_r == '0)) begin
      misses_r <= lsct_pkg::sat_inc(misses_r);
    end else if (mem_we) begin
      use_clock_r <= tick_nxt;
      if (found_r) begin
        hits_r <= lsct_pkg::sat_inc(hits_r);
      end else begin
        misses_r <= lsct_pkg::sat_inc(misses_r);
        if (!empty_r) begin
          evicts_r <= lsct_pkg::sat_inc(evicts_r);
        end
      end
    end
  end

  // Result fields, preset to a bypass result on acceptance and overwritten by the update step.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_hit_r     <= 1'b0;
      res_bypass_r  <= 1'b1;
      res_evicted_r <= 1'b0;
      res_slot_r    <= '0;
      res_key_r     <= '0;
    end else if (mem_we) begin
      res_hit_r     <= found_r;
      res_bypass_r  <= 1'b0;
      res_evicted_r <= !found_r && !empty_r;
      res_slot_r    <= pick_idx;
      res_key_r     <= (!found_r && !empty_r) ? least_key_r : '0;
    end
  end

  // Output register: one result beat, held while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_RESULT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_RESULT) && out_free) begin
      out_hit_r     <= res_hit_r;
      out_bypass_r  <= res_bypass_r;
      out_evicted_r <= res_evicted_r;
      out_slot_r    <= lsct_pkg::IDX_OUT_W'(res_slot_r);
      out_key_r     <= res_key_r;
      out_hits_r    <= hits_r;
      out_misses_r  <= misses_r;
      out_evicts_r  <= evicts_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = out_hit_r;
  assign out_bypass         = out_bypass_r;
  assign out_slot_index     = out_slot_r;
  assign out_evicted        = out_evicted_r;
  assign out_evicted_layer  = out_key_r[lsct_pkg::KEY_W-1:lsct_pkg::EXPERT_W];
  assign out_evicted_expert = out_key_r[lsct_pkg::EXPERT_W-1:0];
  assign out_hit_total      = out_hits_r;
  assign out_miss_total     = out_misses_r;
  assign out_evict_total    = out_evicts_r;

endmodule

### tb/lru_slot_cache_tracker_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the LRU slot cache tracker: a queue-fed request
// driver, a result monitor with random stalls and a behavioral LRU predictor.
// Depends on lsct_pkg and lru_slot_cache_tracker.
module lru_slot_cache_tracker_tb;
  import lsct_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 80;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [LAYER_W-1:0]  layer;
    logic [EXPERT_W-1:0] expert;
  } request_t;

  typedef struct packed {
    logic                 hit;
    logic                 bypass;
    logic [IDX_OUT_W-1:0] slot;
    logic                 evicted;
    logic [LAYER_W-1:0]   ev_layer;
    logic [EXPERT_W-1:0]  ev_expert;
    ctr_t                 hits;
    ctr_t                 misses;
    ctr_t                 evicts;
  } lookup_result_t;

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 cfg_we         = 1'b0;
  logic [CFG_W-1:0]     cfg_slot_count = '0;
  logic                 in_valid       = 1'b0;
  logic                 in_stall;
  logic [LAYER_W-1:0]   in_layer_id    = '0;
  logic [EXPERT_W-1:0]  in_expert_id   = '0;
  logic                 out_valid;
  logic                 out_stall      = 1'b0;
  logic                 out_hit;
  logic                 out_bypass;
  logic [IDX_OUT_W-1:0] out_slot_index;
  logic                 out_evicted;
  logic [LAYER_W-1:0]   out_evicted_layer;
  logic [EXPERT_W-1:0]  out_evicted_expert;
  logic [CTR_W-1:0]     out_hit_total;
  logic [CTR_W-1:0]     out_miss_total;
  logic [CTR_W-1:0]     out_evict_total;

  // Predictor state: slot table, use clock, counters and the slot count.
  logic   tbl_valid [MAX_SLOTS];
  key_t   tbl_key   [MAX_SLOTS];
  tick_t  tbl_tick  [MAX_SLOTS];
  tick_t  use_tick;
  ctr_t   hit_cnt;
  ctr_t   miss_cnt;
  ctr_t   evict_cnt;
  int     slots_cfg;

  request_t       requests_todo [$];
  lookup_result_t results_due   [$];

  int err_count     = 0;
  int n_sent        = 0;
  int n_checked     = 0;
  int n_cfg_writes  = 0;
  int idle_cycles   = 0;
  int tx_gap        = 0;
  int tx_quiet      = 0;
  int rx_stall_left = 0;
  int rx_quiet      = 0;

  lru_slot_cache_tracker u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_slot_count     (cfg_slot_count),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_layer_id        (in_layer_id),
    .in_expert_id       (in_expert_id),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_hit            (out_hit),
    .out_bypass         (out_bypass),
    .out_slot_index     (out_slot_index),
    .out_evicted        (out_evicted),
    .out_evicted_layer  (out_evicted_layer),
    .out_evicted_expert (out_evicted_expert),
    .out_hit_total      (out_hit_total),
    .out_miss_total     (out_miss_total),
    .out_evict_total    (out_evict_total)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Gap length in cycles: mostly none or short, a few long, and now and then
  // a quiet stretch with no gaps at all.
  function automatic int pick_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // A slot count write empties the table but keeps the clock and counters.
  function automatic void load_slot_count(input logic [CFG_W-1:0] value);
    slots_cfg = value;
    for (int i = 0; i < MAX_SLOTS; i++) tbl_valid[i] = 1'b0;
  endfunction

  // Looks up one key, updates the LRU table and queues the result it gives.
  function automatic void lookup_and_update(input request_t req);
    key_t           key;
    lookup_result_t r;
    int             n;
    int             pick;
    bit             found;
    bit             empty;
    tick_t          least;
    key   = {req.layer, req.expert};
    n     = (slots_cfg > MAX_SLOTS) ? MAX_SLOTS : slots_cfg;
    r     = '0;
    pick  = 0;
    found = 1'b0;
    empty = 1'b0;
    least = '1;
    if (n == 0) begin
      r.bypass = 1'b1;
      if (miss_cnt != '1) miss_cnt++;
    end else begin
      for (int i = 0; i < n && !found; i++) begin
        if (tbl_valid[i] && tbl_key[i] == key) begin
          found = 1'b1;
          pick  = i;
        end
      end
      if (found) begin
        r.hit = 1'b1;
        use_tick++;
        tbl_tick[pick] = use_tick;
        if (hit_cnt != '1) hit_cnt++;
      end else begin
        if (miss_cnt != '1) miss_cnt++;
        // The first empty slot wins; otherwise the oldest tick, lowest index.
        for (int i = 0; i < n && !empty; i++) begin
          if (!tbl_valid[i]) begin
            pick  = i;
            empty = 1'b1;
          end else if (tbl_tick[i] < least) begin
            least = tbl_tick[i];
            pick  = i;
          end
        end
        if (!empty) begin
          r.evicted               = 1'b1;
          {r.ev_layer, r.ev_expert} = tbl_key[pick];
          if (evict_cnt != '1) evict_cnt++;
        end
        tbl_valid[pick] = 1'b1;
        tbl_key[pick]   = key;
        use_tick++;
        tbl_tick[pick]  = use_tick;
      end
      r.slot = IDX_OUT_W'(pick);
    end
    r.hits   = hit_cnt;
    r.misses = miss_cnt;
    r.evicts = evict_cnt;
    results_due.push_back(r);
  endfunction

  function automatic string show(input lookup_result_t r);
    return $sformatf("hit=%0b byp=%0b slot=%0d ev=%0b evkey=%0d/%0d tot=%0d/%0d/%0d",
                     r.hit, r.bypass, r.slot, r.evicted, r.ev_layer, r.ev_expert,
                     r.hits, r.misses, r.evicts);
  endfunction

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  // Request driver: predicts each accepted beat, then presents the next one
  // after a random gap.
  always @(posedge clk) begin : request_driver
    request_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        lookup_and_update(request_t'({in_layer_id, in_expert_id}));
        n_sent++;
        tx_gap = pick_gap(tx_quiet);
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (requests_todo.size() > 0) begin
          nxt = requests_todo.pop_front();
          in_valid     <= 1'b1;
          in_layer_id  <= nxt.layer;
          in_expert_id <= nxt.expert;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each accepted beat against the oldest prediction
  // and stalls the block at random.
  always @(posedge clk) begin : result_monitor
    lookup_result_t got;
    lookup_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_hit, out_bypass, out_slot_index, out_evicted, out_evicted_layer,
               out_evicted_expert, out_hit_total, out_miss_total, out_evict_total};
        if (results_due.size() == 0) begin
          flag_error({"result with nothing pending: ", show(got)});
        end else begin
          want = results_due.pop_front();
          n_checked++;
          if (got !== want)
            flag_error($sformatf("result %0d mismatch\n  expected %s\n  actual   %s",
                                 n_checked, show(want), show(got)));
        end
      end
      if (rx_stall_left > 0) begin
        rx_stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 3) == 0) rx_stall_left = pick_gap(rx_quiet);
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no beat moved for %0d cycles", $realtime, idle_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_access(input int layer, input int expert);
    requests_todo.push_back(request_t'({LAYER_W'(layer), EXPERT_W'(expert)}));
  endtask

  // Waits until every queued request has been sent and every result checked.
  task automatic drain();
    do @(negedge clk);
    while (requests_todo.size() != 0 || in_valid || results_due.size() != 0);
  endtask

  task automatic write_slot_count(input int value);
    @(posedge clk);
    cfg_we         <= 1'b1;
    cfg_slot_count <= CFG_W'(value);
    load_slot_count(CFG_W'(value));
    n_cfg_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Random phase: mostly keys from a pool a bit larger than the active
  // table, so hits and evictions both occur, plus some keys from anywhere.
  task automatic queue_random_phase(input int active, input int count);
    key_t pool [$];
    int   psize;
    key_t k;
    psize = (active == 0) ? 4 : active + $urandom_range(1, active / 2 + 2);
    for (int i = 0; i < psize; i++) pool.push_back(key_t'($urandom));
    repeat (count) begin
      if ($urandom_range(0, 9) < 8) k = pool[$urandom_range(0, psize - 1)];
      else k = key_t'($urandom);
      requests_todo.push_back(request_t'(k));
    end
  endtask

  initial begin : stimulus
    int settings [];
    int active;
    settings  = '{1, 3, 127, 0, 8, 2, 64, 5, 16, 100, 4, 12, 65, 7, 1, 6};
    use_tick  = '0;
    hit_cnt   = '0;
    miss_cnt  = '0;
    evict_cnt = '0;
    load_slot_count('0);
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Out of reset the slot count is zero, so every lookup bypasses.
    push_access(0, 0);
    push_access(127, 511);
    push_access(127, 511);
    drain();

    // Two slots: fill both, hit, evict the least recently used twice, then hit again.
    write_slot_count(2);
    push_access(0, 0);
    push_access(127, 511);
    push_access(0, 0);
    push_access(64, 256);
    push_access(127, 511);
    push_access(64, 256);
    drain();

    // Rewriting the count empties the table while counters keep going.
    write_slot_count(2);
    push_access(64, 256);
    push_access(64, 256);
    drain();

    // A count above the table depth uses the whole table.
    write_slot_count(127);
    push_access(1, 1);
    push_access(1, 1);
    push_access(85, 170);
    push_access(42, 341);
    drain();

    // A single slot: every new key evicts the previous one.
    write_slot_count(1);
    push_access(3, 3);
    push_access(3, 3);
    push_access(4, 4);
    drain();

    // Random phases across bypass, small tables, the full table and beyond.
    foreach (settings[i]) begin
      active = (settings[i] > MAX_SLOTS) ? MAX_SLOTS : settings[i];
      write_slot_count(settings[i]);
      queue_random_phase(active, (active >= 32) ? 140 : 65);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (results_due.size() != 0)
      flag_error($sformatf("%0d predicted results never arrived", results_due.size()));

    $display("Checked %0d of %0d lookups over %0d slot-count writes (bypass up to 127).",
             n_checked, n_sent, n_cfg_writes);
    $display("Predicted totals: %0d hits, %0d misses, %0d evictions.",
             hit_cnt, miss_cnt, evict_cnt);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
